@@ hw/rtl/pdrv_pkg.sv @@
// Shared constants, types and the microcode table of the PID position drive.
package pdrv_pkg;

	// Loop constants
	localparam int COUNTS_PER_TURN = 1050;
	localparam int FRAC_BITS       = 16;
	localparam int ANGLE_MUL       = 360;
	localparam int ERR_DIV         = 500;
	localparam int DERIV_MUL       = 500;
	localparam int DEAD_DEG        = 6;
	localparam int DRIVE_MAX       = 255;

	// Field and datapath widths
	localparam int CNT_W      = 32;
	localparam int GAIN_W     = 24;
	localparam int MIN_W      = 8;
	localparam int DRV_W      = 9;
	localparam int DUTY_W     = 8;
	localparam int INT_W      = 48;
	localparam int OPA_W      = 48;
	localparam int HALF_W     = 24;
	localparam int PP_W       = HALF_W + GAIN_W;
	localparam int PROD_W     = OPA_W + GAIN_W;
	localparam int PSAT_W     = 61;
	localparam int ACC_W      = 64;
	localparam int SUM_SHIFT  = FRAC_BITS + 16;
	localparam int CFG_IDX_W  = 8;

	// Angle numerator |count|*360, scaled by 2^FRAC_BITS before the divide
	localparam int MAG_W      = CNT_W + $clog2(ANGLE_MUL);
	localparam int NUM_W      = MAG_W + FRAC_BITS;
	localparam int DVD_W      = ((NUM_W + 3) / 4) * 4;
	localparam int ANG_DIGITS = DVD_W / 4;
	localparam int ERR_DIGITS = CNT_W / 4;
	localparam int DIG_W      = $clog2(ANG_DIGITS);
	localparam int EW         = DVD_W + 2;
	localparam int DIV_MAX    = (COUNTS_PER_TURN > ERR_DIV) ? COUNTS_PER_TURN : ERR_DIV;
	localparam int REM_W      = $clog2(DIV_MAX);
	localparam int XW         = REM_W + 4;

	localparam logic [CNT_W-1:0]  DEAD_LIM = CNT_W'(DEAD_DEG << FRAC_BITS);
	localparam logic [PSAT_W-1:0] PROD_LIM = PSAT_W'(1) << 60;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KI  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_KD  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_MIN = CFG_IDX_W'(3);

	localparam logic [GAIN_W-1:0] KP_RESET  = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] KI_RESET  = GAIN_W'(0);
	localparam logic [GAIN_W-1:0] KD_RESET  = GAIN_W'(655);
	localparam logic [MIN_W-1:0]  MIN_RESET = MIN_W'(255);

	// Microcode fields
	typedef enum logic [3:0] {
		OP_IDLE, OP_NOP, OP_MUL_LO, OP_MUL_HI, OP_MUL_ADD, OP_DIV_LD_ANG,
		OP_DIV_LD_ERR, OP_DIV_STEP, OP_ERR, OP_INTEG, OP_ACC, OP_DONE
	} op_t;

	typedef enum logic [2:0] {B_360, B_500, B_KP, B_KI, B_KD} bsel_t;

	typedef enum logic [2:0] {LD_NONE, LD_ERR, LD_INTEG, LD_DIFF, LD_PROD} ld_t;

	typedef enum logic {DV_CPT, DV_500} dv_t;

	typedef enum logic [2:0] {J_NEXT, J_ALWAYS, J_NO_ITEM, J_DIV_BUSY, J_OUT_BUSY} cond_t;

	localparam int UC_LEN = 28;
	localparam int STEP_W = $clog2(UC_LEN);

	localparam logic [STEP_W-1:0] ST_IDLE  = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_DIV_A = STEP_W'(5);
	localparam logic [STEP_W-1:0] ST_DIV_E = STEP_W'(8);
	localparam logic [STEP_W-1:0] ST_DONE  = STEP_W'(26);

	typedef struct packed {
		op_t               op;
		bsel_t             bsel;
		ld_t               ld;
		dv_t               dv;
		cond_t             cond;
		logic [STEP_W-1:0] tgt;
	} ucw_t;

	// Result of one radix-16 division step
	typedef struct packed {
		logic [3:0]       digit;
		logic [REM_W-1:0] rem;
	} dstep_t;

	function automatic ucw_t uw(op_t op, bsel_t bsel, ld_t ld, dv_t dv, cond_t cond,
			logic [STEP_W-1:0] tgt);
		ucw_t w;
		w.op   = op;
		w.bsel = bsel;
		w.ld   = ld;
		w.dv   = dv;
		w.cond = cond;
		w.tgt  = tgt;
		return w;
	endfunction

	// Control program: angle, error, integral, derivative, then the three products
	function automatic ucw_t uc_rom(logic [STEP_W-1:0] s);
		ucw_t w;
		case (s)
			0:  w = uw(OP_IDLE,       B_360, LD_NONE,  DV_CPT, J_NO_ITEM,  ST_IDLE);
			1:  w = uw(OP_MUL_LO,     B_360, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			2:  w = uw(OP_MUL_HI,     B_360, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			3:  w = uw(OP_MUL_ADD,    B_360, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			4:  w = uw(OP_DIV_LD_ANG, B_360, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			5:  w = uw(OP_DIV_STEP,   B_360, LD_NONE,  DV_CPT, J_DIV_BUSY, ST_DIV_A);
			6:  w = uw(OP_ERR,        B_360, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			7:  w = uw(OP_DIV_LD_ERR, B_360, LD_NONE,  DV_500, J_NEXT,     ST_IDLE);
			8:  w = uw(OP_DIV_STEP,   B_360, LD_NONE,  DV_500, J_DIV_BUSY, ST_DIV_E);
			9:  w = uw(OP_INTEG,      B_360, LD_DIFF,  DV_CPT, J_NEXT,     ST_IDLE);
			10: w = uw(OP_MUL_LO,     B_500, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			11: w = uw(OP_MUL_HI,     B_500, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			12: w = uw(OP_MUL_ADD,    B_500, LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			13: w = uw(OP_NOP,        B_500, LD_PROD,  DV_CPT, J_NEXT,     ST_IDLE);
			14: w = uw(OP_MUL_LO,     B_KD,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			15: w = uw(OP_MUL_HI,     B_KD,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			16: w = uw(OP_MUL_ADD,    B_KD,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			17: w = uw(OP_ACC,        B_KD,  LD_ERR,   DV_CPT, J_NEXT,     ST_IDLE);
			18: w = uw(OP_MUL_LO,     B_KP,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			19: w = uw(OP_MUL_HI,     B_KP,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			20: w = uw(OP_MUL_ADD,    B_KP,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			21: w = uw(OP_ACC,        B_KP,  LD_INTEG, DV_CPT, J_NEXT,     ST_IDLE);
			22: w = uw(OP_MUL_LO,     B_KI,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			23: w = uw(OP_MUL_HI,     B_KI,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			24: w = uw(OP_MUL_ADD,    B_KI,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			25: w = uw(OP_ACC,        B_KI,  LD_NONE,  DV_CPT, J_NEXT,     ST_IDLE);
			26: w = uw(OP_DONE,       B_360, LD_NONE,  DV_CPT, J_OUT_BUSY, ST_DONE);
			27: w = uw(OP_NOP,        B_360, LD_NONE,  DV_CPT, J_ALWAYS,   ST_IDLE);
			default: w = uw(OP_NOP,   B_360, LD_NONE,  DV_CPT, J_ALWAYS,   ST_IDLE);
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/pdrv_divstep.sv @@
// One radix-16 step of restoring division by a constant divisor.
module pdrv_divstep (
	input  logic [pdrv_pkg::REM_W-1:0] rem,
	input  logic [3:0]                 nib,
	input  pdrv_pkg::dv_t              dv,
	output pdrv_pkg::dstep_t           res
);
	import pdrv_pkg::*;

	logic [XW-1:0] x;
	logic [XW-1:0] mlt [16];
	logic [XW-1:0] sub;
	logic [3:0]    dig;

	assign x = {rem, nib};

	// Form the sixteen divisor multiples, zero to fifteen times the selected divisor
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			if (dv == DV_CPT) begin
				mlt[k] = XW'(k * COUNTS_PER_TURN);
			end else begin
				mlt[k] = XW'(k * ERR_DIV);
			end
		end
	end

	// Pick the largest multiple that fits and subtract it
	always_comb begin
		dig = 4'd0;
		sub = mlt[0];
		for (int k = 1; k < 16; k++) begin
			if (x >= mlt[k]) begin
				dig = 4'(k);
				sub = mlt[k];
			end
		end
		res.digit = dig;
		res.rem   = REM_W'(x - sub);
	end

endmodule

@@ hw/rtl/pid_position_motor_drive.sv @@
// PID position drive: step counter, microcode table and shared datapath.
//
// Usage: one transfer on the input channel carries an encoder count, a target
// angle (signed Q16.16 degrees) and a homed flag. An item with homed low is
// taken and produces nothing. A homed item runs the control program: one
// 24x24 multiplier used in low-half, high-half and add passes for the angle,
// derivative and gain products, and a radix-16 constant divider for the
// angle conversion (15 digits) and the integral step (8 digits).
// A new item is taken only once the program for the previous one has finished.
// The input channel is ready only while the sequencer sits at its first step.
// The result sits in an output register; the next item is taken and worked on
// while it waits, and the sequencer holds at its final step only if the
// previous result has still not been taken.
// Configuration: cfg_index selects kp_gain, ki_gain, kd_gain or min_drive,
// cfg_data carries the value; writing ki_gain clears the integral. Other
// indexes are ignored. cfg_ready is always high.
// Reset: gains return to their defaults, integral and previous error clear,
// the output channel empties and the sequencer returns to its first step.
module pid_position_motor_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [pdrv_pkg::CNT_W-1:0]  encoder_count,
	input  logic signed [pdrv_pkg::CNT_W-1:0]  target_position,
	input  logic                               homed,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pdrv_pkg::DRV_W-1:0]  drive,
	output logic [pdrv_pkg::DUTY_W-1:0]        duty_a,
	output logic [pdrv_pkg::DUTY_W-1:0]        duty_b,
	output logic signed [pdrv_pkg::CNT_W-1:0]  position_error,
	output logic                               in_deadband,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pdrv_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdrv_pkg::GAIN_W-1:0]        cfg_data
);
	import pdrv_pkg::*;

	// Sequencer and configuration
	logic [STEP_W-1:0]       step_q;
	logic [STEP_W-1:0]       step_d;
	ucw_t                    uw_c;
	logic                    jump;
	logic [GAIN_W-1:0]       kp_q, ki_q, kd_q;
	logic [MIN_W-1:0]        mn_q;

	// Datapath registers
	logic signed [CNT_W-1:0] cnt_q, tgt_q;
	logic [OPA_W-1:0]        opa_q;
	logic                    opneg_q;
	logic [PP_W-1:0]         pp_q;
	logic [PROD_W-1:0]       prod_q;
	logic [ACC_W-1:0]        acc_q;
	logic [DVD_W-1:0]        dvd_q;
	logic [REM_W-1:0]        rem_q;
	logic [DIG_W-1:0]        dig_q;
	logic signed [CNT_W-1:0] err_q;
	logic signed [INT_W-1:0] integ_q;
	logic signed [CNT_W-1:0] prev_q;

	// Output register
	logic                    out_valid_q;
	logic signed [DRV_W-1:0] drive_q;
	logic [DUTY_W-1:0]       duty_a_q, duty_b_q;
	logic signed [CNT_W-1:0] perr_q;
	logic                    dead_q;

	// Combinational values
	logic                    take_in;
	logic                    out_free;
	logic                    done_go;
	logic [GAIN_W-1:0]       bval;
	logic [HALF_W-1:0]       mul_a;
	logic [PP_W-1:0]         mul_p;
	dstep_t                  dres;
	logic [CNT_W-1:0]        err_mag;
	logic [EW-1:0]           tgt_x, ang_x, ef;
	logic                    ef_ovf;
	logic [CNT_W-1:0]        err_sat;
	logic [INT_W:0]          isum;
	logic [INT_W-1:0]        integ_new;
	logic [CNT_W:0]          diff;
	logic [CNT_W:0]          diff_mag;
	logic [INT_W-1:0]        integ_mag;
	logic [PSAT_W-1:0]       psat;
	logic [ACC_W-1:0]        sum_mag;
	logic [ACC_W-1:0]        dmag;
	logic [DUTY_W-1:0]       dval;
	logic                    dead_c;
	logic                    zero_c;

	assign uw_c      = uc_rom(step_q);
	assign in_ready  = (uw_c.op == OP_IDLE);
	assign cfg_ready = 1'b1;
	assign take_in   = in_valid && in_ready && homed;
	assign out_free  = !out_valid_q || out_ready;
	assign done_go   = (uw_c.op == OP_DONE) && out_free;

	// Choose the next step: fall through or take the row's jump
	always_comb begin
		case (uw_c.cond)
			J_NEXT:     jump = 1'b0;
			J_ALWAYS:   jump = 1'b1;
			J_NO_ITEM:  jump = !take_in;
			J_DIV_BUSY: jump = (dig_q != '0);
			J_OUT_BUSY: jump = !out_free;
			default:    jump = 1'b1;
		endcase
		step_d = jump ? uw_c.tgt : STEP_W'(step_q + STEP_W'(1));
	end

	// Multiplier operands: one half of the magnitude against the selected factor
	always_comb begin
		case (uw_c.bsel)
			B_360:   bval = GAIN_W'(ANGLE_MUL);
			B_500:   bval = GAIN_W'(DERIV_MUL);
			B_KP:    bval = kp_q;
			B_KI:    bval = ki_q;
			B_KD:    bval = kd_q;
			default: bval = kp_q;
		endcase
		mul_a = (uw_c.op == OP_MUL_HI) ? opa_q[OPA_W-1:HALF_W] : opa_q[HALF_W-1:0];
		mul_p = PP_W'(mul_a) * PP_W'(bval);
	end

	pdrv_divstep u_divstep (
		.rem (rem_q),
		.nib (dvd_q[DVD_W-1 -: 4]),
		.dv  (uw_c.dv),
		.res (dres)
	);

	// Error: target minus signed angle, saturated to 32 bits
	always_comb begin
		err_mag = err_q[CNT_W-1] ? CNT_W'(-err_q) : CNT_W'(err_q);
		tgt_x   = EW'(tgt_q);
		ang_x   = EW'(dvd_q);
		ef      = cnt_q[CNT_W-1] ? EW'(tgt_x + ang_x) : EW'(tgt_x - ang_x);
		ef_ovf  = !((&ef[EW-1:CNT_W-1]) || !(|ef[EW-1:CNT_W-1]));
		if (ef_ovf) begin
			err_sat = ef[EW-1] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
		end else begin
			err_sat = ef[CNT_W-1:0];
		end
	end

	// Integral step with 48-bit saturation, and the error difference
	always_comb begin
		if (err_q[CNT_W-1]) begin
			isum = (INT_W+1)'(integ_q) - (INT_W+1)'(dvd_q[CNT_W-1:0]);
		end else begin
			isum = (INT_W+1)'(integ_q) + (INT_W+1)'(dvd_q[CNT_W-1:0]);
		end
		if (isum[INT_W] != isum[INT_W-1]) begin
			integ_new = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}} : {1'b0, {(INT_W-1){1'b1}}};
		end else begin
			integ_new = isum[INT_W-1:0];
		end
		diff      = (CNT_W+1)'(err_q) - (CNT_W+1)'(prev_q);
		diff_mag  = diff[CNT_W] ? (CNT_W+1)'(-diff) : diff;
		integ_mag = integ_q[INT_W-1] ? INT_W'(-integ_q) : INT_W'(integ_q);
		psat      = (prod_q > PROD_W'(PROD_LIM)) ? PROD_LIM : prod_q[PSAT_W-1:0];
	end

	// Drive: truncate the sum, apply stiction floor, clamp and deadband
	always_comb begin
		sum_mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : acc_q;
		dmag    = sum_mag >> SUM_SHIFT;
		if (dmag == '0) begin
			dval = '0;
		end else if (dmag >= ACC_W'(DRIVE_MAX)) begin
			dval = DUTY_W'(DRIVE_MAX);
		end else if (dmag[DUTY_W-1:0] < mn_q) begin
			dval = mn_q;
		end else begin
			dval = dmag[DUTY_W-1:0];
		end
		dead_c = (err_mag < DEAD_LIM);
		zero_c = dead_c || (dval == '0);
	end

	// Hold the step counter and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_d;
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the result payload when the final step completes its transfer slot
	always_ff @(posedge clk) begin
		if (done_go) begin
			perr_q <= err_q;
			dead_q <= dead_c;
			if (zero_c) begin
				drive_q  <= '0;
				duty_a_q <= DUTY_W'(1);
				duty_b_q <= DUTY_W'(1);
			end else if (acc_q[ACC_W-1]) begin
				drive_q  <= DRV_W'(dval);
				duty_a_q <= dval;
				duty_b_q <= '0;
			end else begin
				drive_q  <= -DRV_W'(dval);
				duty_a_q <= '0;
				duty_b_q <= dval;
			end
		end
	end

	// Configuration registers and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= KP_RESET;
			ki_q    <= KI_RESET;
			kd_q    <= KD_RESET;
			mn_q    <= MIN_RESET;
			integ_q <= '0;
			prev_q  <= '0;
		end else begin
			if (uw_c.op == OP_INTEG) begin
				integ_q <= integ_new;
				prev_q  <= err_q;
			end
			if (done_go && dead_c) begin
				integ_q <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP:  kp_q <= cfg_data;
					REG_KI: begin
						ki_q    <= cfg_data;
						integ_q <= '0;
					end
					REG_KD:  kd_q <= cfg_data;
					REG_MIN: mn_q <= cfg_data[MIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath: one operation per control word
	always_ff @(posedge clk) begin
		case (uw_c.op)
			OP_IDLE: begin
				if (take_in) begin
					cnt_q   <= encoder_count;
					tgt_q   <= target_position;
					opa_q   <= OPA_W'($unsigned(encoder_count[CNT_W-1] ?
						CNT_W'(-encoder_count) : CNT_W'(encoder_count)));
					opneg_q <= 1'b0;
					acc_q   <= '0;
				end
			end
			OP_MUL_LO: pp_q <= mul_p;
			OP_MUL_HI: begin
				prod_q <= PROD_W'(pp_q);
				pp_q   <= mul_p;
			end
			OP_MUL_ADD: prod_q <= prod_q + {pp_q, {HALF_W{1'b0}}};
			OP_DIV_LD_ANG: begin
				dvd_q <= DVD_W'({prod_q[MAG_W-1:0], {FRAC_BITS{1'b0}}});
				rem_q <= '0;
				dig_q <= DIG_W'(ANG_DIGITS - 1);
			end
			OP_DIV_LD_ERR: begin
				dvd_q <= {err_mag, {(DVD_W-CNT_W){1'b0}}};
				rem_q <= '0;
				dig_q <= DIG_W'(ERR_DIGITS - 1);
			end
			OP_DIV_STEP: begin
				dvd_q <= {dvd_q[DVD_W-5:0], dres.digit};
				rem_q <= dres.rem;
				dig_q <= DIG_W'(dig_q - DIG_W'(1));
			end
			OP_ERR: err_q <= err_sat;
			OP_ACC: begin
				if (opneg_q) begin
					acc_q <= acc_q - ACC_W'(psat);
				end else begin
					acc_q <= acc_q + ACC_W'(psat);
				end
			end
			default: ;
		endcase

		// Operand loads for the next multiply pass
		case (uw_c.ld)
			LD_ERR: begin
				opa_q   <= OPA_W'(err_mag);
				opneg_q <= err_q[CNT_W-1];
			end
			LD_INTEG: begin
				opa_q   <= OPA_W'(integ_mag);
				opneg_q <= integ_q[INT_W-1];
			end
			LD_DIFF: begin
				opa_q   <= OPA_W'(diff_mag);
				opneg_q <= diff[CNT_W];
			end
			LD_PROD: opa_q <= prod_q[OPA_W-1:0];
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign drive          = drive_q;
	assign duty_a         = duty_a_q;
	assign duty_b         = duty_b_q;
	assign position_error = perr_q;
	assign in_deadband    = dead_q;

endmodule

@@ hw/rtl/pdrv_checker.sv @@
// Port-level checks for the PID position drive, bound to the top level.
module pdrv_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               homed,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic signed [pdrv_pkg::DRV_W-1:0]  drive,
	input logic [pdrv_pkg::DUTY_W-1:0]        duty_a,
	input logic [pdrv_pkg::DUTY_W-1:0]        duty_b,
	input logic signed [pdrv_pkg::CNT_W-1:0]  position_error,
	input logic                               in_deadband
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(position_error))
		else $error("stalled result changed");

	// Deadband always forces zero drive
	a_dead_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_deadband |-> drive == 0)
		else $error("deadband result with nonzero drive");

	// Zero drive gives both duties one
	a_zero_duty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive == 0 |-> duty_a == 8'd1 && duty_b == 8'd1)
		else $error("zero drive with wrong duties");

	// Nonzero drive powers exactly one bridge side
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive != 0 |-> (duty_a == 8'd0) != (duty_b == 8'd0))
		else $error("nonzero drive on both or neither side");

	// A homed transfer occupies the sequencer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && homed |=> !in_ready)
		else $error("input ready straight after a homed transfer");

endmodule

bind pid_position_motor_drive pdrv_checker u_pdrv_checker (.*);

@@ dv/tb_pid_position_motor_drive.sv @@
// Self-checking testbench for the PID position drive, with a tick scoreboard.
`timescale 1ns / 1ps

module tb_pid_position_motor_drive;

	localparam int          DEAD_Q       = pdrv_pkg::DEAD_DEG << pdrv_pkg::FRAC_BITS;
	localparam int          SETTLE       = 64;
	localparam int          PARK_CYCLES  = 600;
	localparam int unsigned LIMIT_CYCLES = 2000000;
	localparam longint      ERR_TOP      = 64'sd2147483647;
	localparam longint      ERR_BOT      = -64'sd2147483648;
	localparam longint      INTEG_TOP    = 64'sd140737488355327;
	localparam longint      INTEG_BOT    = -64'sd140737488355328;
	localparam logic [pdrv_pkg::CFG_IDX_W-1:0] REG_FIRST_SPARE = pdrv_pkg::REG_MIN + 8'd1;

	// Tracks loop state and gains, works out each tick's drive and checks the outputs
	class tick_scoreboard;
		typedef struct {
			logic signed [pdrv_pkg::DRV_W-1:0] drive;
			logic [pdrv_pkg::DUTY_W-1:0]       duty_a;
			logic [pdrv_pkg::DUTY_W-1:0]       duty_b;
			logic signed [pdrv_pkg::CNT_W-1:0] perr;
			logic                              dead;
		} drive_res_t;

		drive_res_t                pending_drives[$];
		logic [pdrv_pkg::GAIN_W-1:0] kp, ki, kd;
		logic [pdrv_pkg::MIN_W-1:0]  min_drv;
		longint                    integ, last_err;
		int                        failures;

		function new();
			kp       = pdrv_pkg::KP_RESET;
			ki       = pdrv_pkg::KI_RESET;
			kd       = pdrv_pkg::KD_RESET;
			min_drv  = pdrv_pkg::MIN_RESET;
			integ    = 0;
			last_err = 0;
			failures = 0;
		endfunction

		function void set_reg(logic [pdrv_pkg::CFG_IDX_W-1:0] idx,
				logic [pdrv_pkg::GAIN_W-1:0] data);
			case (idx)
				pdrv_pkg::REG_KP:  kp = data;
				pdrv_pkg::REG_KI: begin
					ki    = data;
					integ = 0;
				end
				pdrv_pkg::REG_KD:  kd = data;
				pdrv_pkg::REG_MIN: min_drv = data[pdrv_pkg::MIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Count to Q16.16 degrees, magnitude truncated toward zero
		function longint angle_of(logic signed [pdrv_pkg::CNT_W-1:0] cnt);
			longint          c;
			longint unsigned mag, num, a;
			c   = cnt;
			mag = (c < 0) ? -c : c;
			num = mag * pdrv_pkg::ANGLE_MUL;
			// quotient never reaches the cap for a 32-bit count
			a   = ((num / pdrv_pkg::COUNTS_PER_TURN) << pdrv_pkg::FRAC_BITS)
			    + (((num % pdrv_pkg::COUNTS_PER_TURN) << pdrv_pkg::FRAC_BITS)
			    / pdrv_pkg::COUNTS_PER_TURN);
			return (c < 0) ? -longint'(a) : longint'(a);
		endfunction

		// Gain product with its magnitude held at 2^60
		function longint scaled_product(longint v, logic [pdrv_pkg::GAIN_W-1:0] g);
			longint unsigned m, p, gu, lim;
			lim = 64'd1 << 60;
			gu  = g;
			m   = (v < 0) ? -v : v;
			if (gu != 0 && m > lim / gu)
				p = lim;
			else
				p = m * gu;
			if (p > lim)
				p = lim;
			return (v < 0) ? -longint'(p) : longint'(p);
		endfunction

		function void take_tick(logic signed [pdrv_pkg::CNT_W-1:0] cnt,
				logic signed [pdrv_pkg::CNT_W-1:0] tgt, logic hm);
			longint          err, rate, total, drv, floor_mag;
			longint unsigned mag;
			logic            dead;
			drive_res_t      res;
			if (!hm)
				return;
			err = longint'(tgt) - angle_of(cnt);
			if (err > ERR_TOP)
				err = ERR_TOP;
			else if (err < ERR_BOT)
				err = ERR_BOT;

			integ += err / pdrv_pkg::ERR_DIV;
			if (integ > INTEG_TOP)
				integ = INTEG_TOP;
			else if (integ < INTEG_BOT)
				integ = INTEG_BOT;
			rate = (err - last_err) * pdrv_pkg::DERIV_MUL;

			// PID sum, truncated toward zero
			total = scaled_product(err, kp) + scaled_product(integ, ki)
			      + scaled_product(rate, kd);
			mag   = (total < 0) ? -total : total;
			mag   = mag >> pdrv_pkg::SUM_SHIFT;
			drv   = (total < 0) ? -longint'(mag) : longint'(mag);

			// stiction floor, then clamp
			floor_mag = min_drv;
			if (drv > 0 && drv < floor_mag)
				drv = floor_mag;
			else if (drv < 0 && drv > -floor_mag)
				drv = -floor_mag;
			if (drv > pdrv_pkg::DRIVE_MAX)
				drv = pdrv_pkg::DRIVE_MAX;
			else if (drv < -pdrv_pkg::DRIVE_MAX)
				drv = -pdrv_pkg::DRIVE_MAX;

			dead = ((err < 0) ? -err : err) < DEAD_Q;
			if (dead) begin
				drv   = 0;
				integ = 0;
			end
			last_err = err;
			drv      = -drv;

			res.drive  = drv[pdrv_pkg::DRV_W-1:0];
			res.duty_a = (drv > 0) ? drv[7:0] : ((drv < 0) ? 8'd0 : 8'd1);
			res.duty_b = (drv < 0) ? 8'(-drv) : ((drv > 0) ? 8'd0 : 8'd1);
			res.perr   = err[pdrv_pkg::CNT_W-1:0];
			res.dead   = dead;
			pending_drives.push_back(res);
		endfunction

		function void check_drive(logic signed [pdrv_pkg::DRV_W-1:0] drv,
				logic [pdrv_pkg::DUTY_W-1:0] da, logic [pdrv_pkg::DUTY_W-1:0] db,
				logic signed [pdrv_pkg::CNT_W-1:0] perr, logic dead);
			drive_res_t want;
			if (pending_drives.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("%0t: result with nothing pending: drive %0d error %0d",
						$time, drv, perr);
				return;
			end
			want = pending_drives.pop_front();
			if (want.drive !== drv || want.duty_a !== da || want.duty_b !== db
					|| want.perr !== perr || want.dead !== dead) begin
				failures++;
				if (failures <= 10)
					$display({"%0t: mismatch: expected drive %0d duty %0d/%0d error %0d",
						" dead %0b, got drive %0d duty %0d/%0d error %0d dead %0b"},
						$time, want.drive, want.duty_a, want.duty_b, want.perr,
						want.dead, drv, da, db, perr, dead);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [pdrv_pkg::CNT_W-1:0] encoder_count = '0;
	logic signed [pdrv_pkg::CNT_W-1:0] target_position = '0;
	logic homed = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [pdrv_pkg::DRV_W-1:0] drive;
	logic [pdrv_pkg::DUTY_W-1:0] duty_a;
	logic [pdrv_pkg::DUTY_W-1:0] duty_b;
	logic signed [pdrv_pkg::CNT_W-1:0] position_error;
	logic in_deadband;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [pdrv_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pdrv_pkg::GAIN_W-1:0] cfg_data = '0;

	tick_scoreboard sb;
	bit             no_idle = 1'b0;
	logic           park_results = 1'b0;
	int unsigned    cycle_count = 0;
	int             walk_cnt = 0;
	logic signed [pdrv_pkg::CNT_W-1:0] walk_tgt = '0;

	pid_position_motor_drive uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.encoder_count   (encoder_count),
		.target_position (target_position),
		.homed           (homed),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.drive           (drive),
		.duty_a          (duty_a),
		.duty_b          (duty_b),
		.position_error  (position_error),
		.in_deadband     (in_deadband),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #1 clk = ~clk;

	// Mostly short gaps, a few long ones, none while the phase runs flat out
	function automatic int pick_gap(bit calm);
		int roll;
		roll = $urandom_range(0, 99);
		if (calm || roll < 45)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 4);
		if (roll < 97)
			return $urandom_range(5, 24);
		return $urandom_range(40, 120);
	endfunction

	// Target a short way off the measured angle: inside, on or well past the deadband
	function automatic logic signed [pdrv_pkg::CNT_W-1:0] near_angle(
			logic signed [pdrv_pkg::CNT_W-1:0] cnt);
		longint mag, pos;
		case ($urandom_range(0, 3))
			0:       mag = $urandom_range(0, DEAD_Q - 1);
			1:       mag = DEAD_Q - 2 + $urandom_range(0, 3);
			default: mag = $urandom_range(0, 90 << pdrv_pkg::FRAC_BITS);
		endcase
		pos = sb.angle_of(cnt) + (($urandom_range(0, 1) != 0) ? -mag : mag);
		if (pos > ERR_TOP)
			pos = ERR_TOP;
		else if (pos < ERR_BOT)
			pos = ERR_BOT;
		return pos[pdrv_pkg::CNT_W-1:0];
	endfunction

	task automatic send_tick(logic signed [pdrv_pkg::CNT_W-1:0] cnt,
			logic signed [pdrv_pkg::CNT_W-1:0] tgt, logic hm);
		int gap;
		in_valid        <= 1'b1;
		encoder_count   <= cnt;
		target_position <= tgt;
		homed           <= hm;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_tick(cnt, tgt, hm);
		gap = pick_gap(no_idle);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [pdrv_pkg::CFG_IDX_W-1:0] idx,
			logic [pdrv_pkg::GAIN_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic load_gains(logic [pdrv_pkg::GAIN_W-1:0] p, logic [pdrv_pkg::GAIN_W-1:0] i,
			logic [pdrv_pkg::GAIN_W-1:0] d, logic [pdrv_pkg::GAIN_W-1:0] m,
			logic [pdrv_pkg::CFG_IDX_W-1:0] spare_idx);
		write_reg(spare_idx, 24'($urandom));
		write_reg(pdrv_pkg::REG_KP, p);
		write_reg(pdrv_pkg::REG_KI, i);
		write_reg(pdrv_pkg::REG_KD, d);
		write_reg(pdrv_pkg::REG_MIN, m);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering, wait for every pending result, then let the sequencer settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending_drives.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Mostly a slowly moving encoder chasing a held target, plus wild and ignored ticks
	task automatic run_ticks(int n_homed);
		int   sent, roll;
		logic signed [pdrv_pkg::CNT_W-1:0] cnt, tgt;
		logic hm;
		sent = 0;
		while (sent < n_homed) begin
			roll = $urandom_range(0, 99);
			hm   = 1'b1;
			if (roll < 8) begin
				cnt = $urandom;
				tgt = $urandom;
				hm  = 1'b0;
			end else if (roll < 18) begin
				cnt = $urandom;
				tgt = $urandom;
			end else if (roll < 35) begin
				cnt = int'($urandom_range(0, 40000)) - 20000;
				tgt = near_angle(cnt);
			end else begin
				if ($urandom_range(0, 19) == 0)
					walk_tgt = near_angle(walk_cnt);
				walk_cnt += int'($urandom_range(0, 30)) - 15;
				cnt = walk_cnt;
				tgt = walk_tgt;
			end
			send_tick(cnt, tgt, hm);
			if (hm)
				sent++;
		end
	endtask

	function automatic logic [pdrv_pkg::GAIN_W-1:0] pick_gain(int unsigned top);
		if ($urandom_range(0, 4) == 0)
			return 24'($urandom);
		return 24'($urandom_range(0, top));
	endfunction

	// Check every result transfer against the oldest pending tick
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_drive(drive, duty_a, duty_b, position_error, in_deadband);
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_pid_position_motor_drive: errors");
			$finish;
		end
	end

	// Result side: take a transfer, then stall at random or park for a long stretch
	initial begin : result_side
		int gap;
		@(posedge arst_n);
		forever begin
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (park_results) begin
				park_results <= 1'b0;
				gap = PARK_CYCLES;
			end else begin
				gap = pick_gap(no_idle);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int ph;
		logic [pdrv_pkg::GAIN_W-1:0] min_word;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks at the reset gains
		send_tick(0, 0, 1'b1);
		send_tick(0, DEAD_Q, 1'b1);
		send_tick(0, DEAD_Q - 1, 1'b1);
		send_tick(0, -DEAD_Q, 1'b1);
		send_tick(0, 1 - DEAD_Q, 1'b1);
		send_tick(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
		send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
		send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0);
		send_tick(1050, 360 << pdrv_pkg::FRAC_BITS, 1'b1);
		send_tick(-1, 0, 1'b1);
		send_tick(1, 0, 1'b1);
		send_tick(-1050, -(360 << pdrv_pkg::FRAC_BITS) - DEAD_Q, 1'b1);
		send_tick(7, 32'sh7FFF_FFFF, 1'b1);
		send_tick(-7, 32'sh8000_0000, 1'b1);
		send_tick(0, 0, 1'b0);
		send_tick(3, 5 << pdrv_pkg::FRAC_BITS, 1'b1);
		send_tick(0, 1, 1'b1);
		send_tick(-300, -4 * DEAD_Q, 1'b1);
		drain();

		// Moderate gains with an integral term
		load_gains(24'd196608, 24'd1000, 24'd655, 24'd30, REG_FIRST_SPARE);
		run_ticks(150);
		drain();

		// Every gain at full scale, floor at its top
		load_gains(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'hFF);
		run_ticks(100);
		drain();

		// All gains and the floor at zero
		load_gains(24'd0, 24'd0, 24'd0, 24'd0, 8'h80);
		run_ticks(80);
		drain();

		// Park the result side while ticks keep coming, so the input backs up
		load_gains(24'd131072, 24'd5000, 24'd2000, 24'd60, 8'h7C);
		no_idle = 1'b1;
		park_results <= 1'b1;
		run_ticks(60);
		no_idle = 1'b0;
		drain();

		// Random gain sets
		for (ph = 0; ph < 5; ph++) begin
			if ($urandom_range(0, 3) == 0)
				min_word = {16'($urandom), 8'd0};
			else
				min_word = 24'($urandom);
			load_gains(pick_gain(8 << pdrv_pkg::FRAC_BITS), pick_gain(20000), pick_gain(4000),
				min_word, 8'($urandom_range(REG_FIRST_SPARE, 255)));
			no_idle = (ph == 2);
			run_ticks(110);
			no_idle = 1'b0;
			drain();
		end

		if (sb.failures == 0 && sb.pending_drives.size() == 0)
			$display("tb_pid_position_motor_drive: clean");
		else
			$display("tb_pid_position_motor_drive: errors");
		$finish;
	end

endmodule
